// File: rtl/mcd_pkg.sv
`timescale 1ns / 1ps

package mcd_pkg;

    // Default widths of the timestamp arithmetic and of the click counter.
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 8;

    // Field widths fixed by the interface.
    localparam int NOW_W     = 32;
    localparam int MS_W      = 16;
    localparam int LIMIT_W   = 8;
    localparam int TOTAL_W   = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;

    // Reset values of the configuration registers.
    localparam logic [MS_W-1:0] GAP_RESET     = 16'd400;
    localparam logic [MS_W-1:0] HOLDOFF_RESET = 16'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DETECT_LEVEL = 2'd0,
        REG_BURST_GAP    = 2'd1,
        REG_CLICK_LIMIT  = 2'd2,
        REG_HOLDOFF      = 2'd3
    } mcd_reg_t;

    // Configuration handed from the register bank to the detector core.
    typedef struct packed {
        logic               detect_level;
        logic [MS_W-1:0]    burst_gap_ms;
        logic [LIMIT_W-1:0] click_limit;
        logic [MS_W-1:0]    holdoff_ms;
    } mcd_cfg_t;

    // One result of the detector core.
    typedef struct packed {
        logic               burst_done;
        logic [TOTAL_W-1:0] click_total;
    } mcd_result_t;

endpackage

// File: rtl/mcd_core.sv
`timescale 1ns / 1ps

module mcd_core
    import mcd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  mcd_cfg_t    cfg,
    input  logic        advance,
    input  logic        pin_level,
    input  logic [NOW_W-1:0] now_ms,
    output mcd_result_t res
);

    localparam int CMP_BITS = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  primed_reg;
    logic                  last_level_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TIME_BITS-1:0]  last_click_reg;

    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  elapsed;
    logic [TIME_BITS-1:0]  gap_elapsed;
    logic                  click_edge;
    logic                  blocked;
    logic                  counted;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_BITS-1:0]   count_wide;
    logic                  limit_hit;
    logic                  gap_hit;
    logic                  done;

    // Elapsed time since the last counted click, modulo the timer width.
    assign now_t   = TIME_BITS'(now_ms);
    assign elapsed = now_t - last_click_reg;

    // A change into the detect level is a click; the holdoff only applies
    // inside an open burst.
    assign click_edge = primed_reg && (pin_level != last_level_reg)
                        && (pin_level == cfg.detect_level);
    assign blocked    = (count_reg != '0) && (elapsed < TIME_BITS'(cfg.holdoff_ms));
    assign counted    = click_edge && !blocked;

    always_comb begin
        count_inc = count_reg;
        if (counted && (count_reg != COUNT_MAX)) begin
            count_inc = count_reg + COUNT_BITS'(1);
        end
    end

    // A click counted on this poll restarts the gap timer at zero.
    assign gap_elapsed = counted ? '0 : elapsed;
    assign count_wide  = CMP_BITS'(count_inc);
    assign limit_hit   = (cfg.click_limit != '0)
                         && (count_wide >= CMP_BITS'(cfg.click_limit));
    assign gap_hit     = (count_inc != '0)
                         && (gap_elapsed > TIME_BITS'(cfg.burst_gap_ms));
    assign done        = primed_reg && (limit_hit || gap_hit);

    // Result of this poll; the total saturates at the output width.
    always_comb begin
        res.burst_done  = done;
        res.click_total = '0;
        if (done) begin
            res.click_total = (count_wide > CMP_BITS'({TOTAL_W{1'b1}}))
                              ? {TOTAL_W{1'b1}} : count_wide[TOTAL_W-1:0];
        end
    end

    // Detector state, updated once per accepted poll.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg     <= 1'b0;
            last_level_reg <= 1'b0;
            count_reg      <= '0;
            last_click_reg <= '0;
        end else if (advance) begin
            primed_reg     <= 1'b1;
            last_level_reg <= pin_level;
            count_reg      <= done ? '0 : count_inc;
            if (counted) begin
                last_click_reg <= now_t;
            end
        end
    end

    // The first poll after reset never finishes a burst.
    a_first_poll_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !primed_reg |-> !res.burst_done)
        else $error("burst reported on the first poll");

    // A reported burst leaves the counter cleared.
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.burst_done |=> count_reg == '0)
        else $error("click count not cleared after burst");

    // A counted click stamps its own time.
    a_click_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && counted |=> last_click_reg == $past(now_t))
        else $error("click time not recorded");

endmodule

// File: rtl/multi_click_detector.sv
`timescale 1ns / 1ps

// Multi-click detector for one button pin.
// Input channel (s_): one request per poll, carrying the sampled pin level and
// a free-running millisecond timestamp. Output channel (m_): exactly one
// request per poll, with burst_done in m_tuser and the click count of the
// finished burst in m_tdata (zero when no burst finished).
// Configuration: a plain write port (cfg_wen, cfg_addr, cfg_wdata); index 0
// is the detect level, 1 the burst gap, 2 the click limit, 3 the holdoff.
// Write it only while no poll is in flight.
// Path: an accepted poll lands in the input register, and the detector step
// on it lands in the output register, which drives m_tvalid, once that
// register is empty or being drained.
// Throughput: one poll per cycle while the receiver does not stall; the step
// is a single timestamp subtract with a few compares and a counter increment.
// Reset (aresetn low, synchronous) empties both registers, clears the
// detector state and loads the default configuration.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more poll before s_tready drops.

module multi_click_detector
    import mcd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Poll input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // [0] pin_level, [32:1] now_ms, rest zero
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // [7:0] click_total
    output logic                  m_tuser   // [0] burst_done
);

    mcd_cfg_t         cfg_reg;
    logic             in_valid_reg;
    logic             in_level_reg;
    logic [NOW_W-1:0] in_now_reg;
    logic             out_valid_reg;
    mcd_result_t      out_reg;
    mcd_result_t      step_res;
    logic             advance;

    // Configuration register bank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_level <= 1'b0;
            cfg_reg.burst_gap_ms <= GAP_RESET;
            cfg_reg.click_limit  <= '0;
            cfg_reg.holdoff_ms   <= HOLDOFF_RESET;
        end else if (cfg_wen) begin
            unique case (mcd_reg_t'(cfg_addr))
                REG_DETECT_LEVEL: cfg_reg.detect_level <= cfg_wdata[0];
                REG_BURST_GAP:    cfg_reg.burst_gap_ms <= cfg_wdata[MS_W-1:0];
                REG_CLICK_LIMIT:  cfg_reg.click_limit  <= cfg_wdata[LIMIT_W-1:0];
                REG_HOLDOFF:      cfg_reg.holdoff_ms   <= cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // The input register moves into the output register when that one is
    // empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[NOW_W:1];
        end
    end

    mcd_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .advance   (advance),
        .pin_level (in_level_reg),
        .now_ms    (in_now_reg),
        .res       (step_res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg.click_total);
    assign m_tuser  = out_reg.burst_done;

    // A poll waiting in the input register is never dropped.
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending poll lost");

    // A result is only loaded into an output register that is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while stalled");

    // With the output stalled, the input side can hold at most one poll.
    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready && in_valid_reg |-> !s_tready)
        else $error("poll taken while both registers are full");

endmodule

// File: tb/sv/multi_click_detector_tb.sv
`timescale 1ns / 1ps

// Tracks detector state and configuration. Predicts one result for every poll
// and checks each returned result against the oldest prediction.
class click_scoreboard;

    bit        detect_level;
    bit [15:0] burst_gap_ms;
    bit [7:0]  click_limit;
    bit [15:0] holdoff_ms;

    bit        primed;
    bit        last_level;
    bit [7:0]  click_count;
    bit [31:0] last_click_ms;

    mcd_pkg::mcd_result_t burst_reports[$];
    int unsigned          errors;

    function new();
        detect_level  = 1'b0;
        burst_gap_ms  = 16'd400;
        click_limit   = 8'd0;
        holdoff_ms    = 16'd100;
        primed        = 1'b0;
        last_level    = 1'b0;
        click_count   = 8'd0;
        last_click_ms = 32'd0;
        errors        = 0;
    endfunction

    // Advance the detector by one accepted poll and queue the result it causes.
    function void note_poll(bit lvl, bit [31:0] now_ms);
        bit [31:0]            since;
        mcd_pkg::mcd_result_t res;
        res = '0;
        if (!primed) begin
            primed     = 1'b1;
            last_level = lvl;
        end else begin
            // An edge into the detect level is a click unless it falls inside
            // the holdoff of an open burst.
            if (lvl != last_level && lvl == detect_level) begin
                since = now_ms - last_click_ms;
                if (click_count == 0 || since >= holdoff_ms) begin
                    if (click_count != 8'hFF)
                        click_count++;
                    last_click_ms = now_ms;
                end
            end
            last_level = lvl;
            // Close the burst on the click limit or once the gap has run out.
            since = now_ms - last_click_ms;
            if ((click_limit != 0 && click_count >= click_limit) ||
                (click_count != 0 && since > burst_gap_ms)) begin
                res.burst_done  = 1'b1;
                res.click_total = click_count;
                click_count     = 8'd0;
            end
        end
        burst_reports.push_back(res);
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Compare one returned result with the oldest prediction.
    function void check_result(logic done, logic [7:0] total);
        mcd_pkg::mcd_result_t want;
        if (burst_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual done=%0d total=%0d",
                     $time, done, total);
            return;
        end
        want = burst_reports.pop_front();
        if (done !== want.burst_done)
            report("burst_done", 8'(want.burst_done), 8'(done));
        if (total !== want.click_total)
            report("click_total", want.click_total, total);
    endfunction

    function int pending();
        return burst_reports.size();
    endfunction

endclass

module multi_click_detector_tb
    import mcd_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam bit [31:0]   WRAP_START  = 32'hFFFF_FFC0;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wen;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    click_scoreboard sb;
    bit              idle_on;
    bit [31:0]       press_ms;
    int unsigned     cycle_count = 0;

    multi_click_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Watch both channels; predict on each accepted poll, check each result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_poll(s_tdata[0], s_tdata[32:1]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // Result receiver with random stall bursts.
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Send one poll request and wait until it is taken.
    task automatic send_poll(input bit lvl, input bit [31:0] now_ms);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({now_ms, lvl});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all four registers; junk is put in the bits above the narrow ones.
    task automatic set_config(input bit lvl, input bit [15:0] gap,
                              input bit [7:0] limit, input bit [15:0] hold);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_DETECT_LEVEL;
        cfg_wdata <= {15'($urandom), lvl};
        @(posedge aclk);
        cfg_addr  <= REG_BURST_GAP;
        cfg_wdata <= gap;
        @(posedge aclk);
        cfg_addr  <= REG_CLICK_LIMIT;
        cfg_wdata <= {8'($urandom), limit};
        @(posedge aclk);
        cfg_addr  <= REG_HOLDOFF;
        cfg_wdata <= hold;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        sb.detect_level = lvl;
        sb.burst_gap_ms = gap;
        sb.click_limit  = limit;
        sb.holdoff_ms   = hold;
    endtask

    // A value just below, at, or just above a threshold.
    function automatic int unsigned near_value(int unsigned v);
        if (v == 0)
            return $urandom_range(0, 1);
        return v - 1 + $urandom_range(0, 2);
    endfunction

    // Time from one press to the next, aimed at the holdoff and gap edges.
    function automatic bit [31:0] pick_spacing(bit tight);
        if (tight)
            return $urandom_range(0, 20);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 3);
            1, 2: return near_value(sb.holdoff_ms);
            3: return near_value(sb.burst_gap_ms);
            4: return $urandom_range(0, sb.holdoff_ms);
            5: return $urandom_range(sb.holdoff_ms,
                                     32'(sb.burst_gap_ms) + 32'(sb.holdoff_ms));
            6: return $urandom_range(0, 32'(sb.burst_gap_ms) + 32'd1);
            default: return $urandom;
        endcase
    endfunction

    // Release/press pairs with random timing and some stray polls; a final
    // poll past the gap closes whatever burst is still open.
    task automatic run_phase(input int pairs, input bit tight);
        bit [31:0] spacing;
        repeat (pairs) begin
            if (!tight && $urandom_range(0, 9) == 0)
                send_poll(1'($urandom_range(0, 1)),
                          press_ms + $urandom_range(0, sb.burst_gap_ms));
            spacing = pick_spacing(tight);
            send_poll(!sb.detect_level, press_ms + $urandom_range(0, spacing));
            press_ms = press_ms + spacing;
            send_poll(sb.detect_level, press_ms);
        end
        send_poll(sb.detect_level, press_ms + sb.burst_gap_ms + 1);
    endtask

    initial begin
        sb        = new();
        idle_on   = 1'b1;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = REG_DETECT_LEVEL;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default configuration: first poll, holdoff and gap edges, timer wrap.
        send_poll(1'b1, WRAP_START);
        send_poll(1'b0, WRAP_START + 32'd10);
        send_poll(1'b1, WRAP_START + 32'd20);
        send_poll(1'b0, WRAP_START + 32'd50);
        send_poll(1'b1, WRAP_START + 32'd60);
        send_poll(1'b0, WRAP_START + 32'd110);
        send_poll(1'b0, WRAP_START + 32'd510);
        send_poll(1'b0, WRAP_START + 32'd511);
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'd399);
        send_poll(1'b0, 32'd400);

        // Zero holdoff, zero gap and a click limit of two.
        set_config(1'b1, 16'd0, 8'd2, 16'd0);
        send_poll(1'b0, 32'd1000);
        send_poll(1'b1, 32'd1000);
        send_poll(1'b0, 32'd1000);
        send_poll(1'b1, 32'd1000);
        send_poll(1'b0, 32'd1000);
        send_poll(1'b1, 32'd1000);
        send_poll(1'b1, 32'd1001);

        press_ms = 32'd5000;
        set_config(1'b1, 16'd400, 8'd3, 16'd100);
        run_phase(70, 1'b0);
        set_config(1'b0, 16'd0, 8'd0, 16'd0);
        run_phase(60, 1'b0);
        press_ms = WRAP_START;
        set_config(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
        run_phase(50, 1'b0);

        // A stretch without idling.
        idle_on = 1'b0;
        set_config(1'b0, 16'd20, 8'd1, 16'd5);
        run_phase(50, 1'b0);
        idle_on = 1'b1;

        // Long burst with no limit: the count saturates.
        set_config(1'b1, 16'hFFFF, 8'd0, 16'd0);
        run_phase(270, 1'b1);

        set_config(1'b0, 16'd1000, 8'd5, 16'd250);
        run_phase(70, 1'b0);
        set_config(1'b1, 16'd50, 8'd2, 16'd0);
        run_phase(50, 1'b0);

        // Random settings, some over the full register range.
        repeat (3) begin
            set_config(1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 600)),
                       8'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 6)),
                       16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 300)));
            run_phase(40, 1'b0);
        end

        // Last part at full rate on both sides.
        idle_on = 1'b0;
        set_config(1'b0, 16'd300, 8'd4, 16'd80);
        run_phase(60, 1'b0);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
